FILE: rtl/scara_ik_pkg.sv
`timescale 1ns / 1ps
// shared constants, arctangent table, register indexes and pipeline types
package scara_ik_pkg;

   localparam int ANGLE_FRAC_BITS = 12;
   localparam int CORDIC_STAGES   = 16;
   localparam int TAB_LEN         = 24;

   // shift from q30 radians down to the output angle format
   localparam int ANG_SHIFT = 30 - ANGLE_FRAC_BITS;

   // q30 angle word
   localparam int ZW = 36;

   localparam logic signed [ZW-1:0] PI_Q30      = 36'sd3373259426;
   localparam logic signed [ZW-1:0] TWO_PI_Q30  = 36'sd6746518852;
   localparam logic signed [ZW-1:0] HALF_PI_Q30 = 36'sd1686629713;
   localparam logic [29:0]          GAIN_Q30    = 30'd652032874;

   localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
      32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
      32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
   };

   // square root operand: (2 l1 l2)^2 stays below 2^58
   localparam int REM_W      = 58;
   localparam int SQRT_STEPS = REM_W / 2;

   // atan2 unit: abs, max, msb search, normalize, quarter turn, cordic, round
   localparam int ATAN_LAT = CORDIC_STAGES + 6;

   localparam logic [1:0] CSR_UPPER_LINK  = 2'd0;
   localparam logic [1:0] CSR_LOWER_LINK  = 2'd1;
   localparam logic [1:0] CSR_TOOL_OFFSET = 2'd2;
   localparam logic [1:0] CSR_VERT_OFFSET = 2'd3;

   // per-item context that rides along the pipeline
   typedef struct packed {
      logic signed [14:0] yaw;
      logic signed [15:0] lift;
      logic signed [14:0] px;
      logic signed [14:0] py;
      logic               neg;
      logic               flip;
      logic signed [17:0] wx;
      logic signed [17:0] wy;
      logic [28:0]        d;
      logic signed [36:0] n;
      logic               unr;
      logic signed [29:0] s;
   } ctx_type;

endpackage

FILE: rtl/scara_ik_atan2.sv
`timescale 1ns / 1ps
// pipelined atan2: normalize to a fixed msb, quarter turn, vectoring cordic, round
module scara_ik_atan2 (
   input  logic               clock,
   input  logic               en,
   input  logic signed [63:0] vec_y,
   input  logic signed [63:0] vec_x,
   output logic signed [14:0] angle
);

   localparam int VW       = 44;
   localparam int NORM_MSB = 40;
   localparam int CS       = scara_ik_pkg::CORDIC_STAGES;
   localparam int LAT      = scara_ik_pkg::ATAN_LAT;
   localparam int ZW       = scara_ik_pkg::ZW;
   localparam int SH       = scara_ik_pkg::ANG_SHIFT;

   logic                 zero_ff [1:LAT-1];
   logic signed [63:0]   x1_ff, y1_ff, x2_ff, y2_ff, x3_ff, y3_ff;
   logic [63:0]          mx1_ff, my1_ff, m2_ff;
   logic [5:0]           pos3_ff, pos_in;
   logic signed [63:0]   xs_in, ys_in;
   logic signed [VW-1:0] xn4_ff, yn4_ff;
   logic signed [VW-1:0] cx_ff [0:CS];
   logic signed [VW-1:0] cy_ff [0:CS];
   logic signed [ZW-1:0] cz_ff [0:CS];
   logic signed [ZW-1:0] zr;
   logic signed [14:0]   angle_ff;

   // msb of the larger magnitude
   always_comb begin
      pos_in = '0;
      for (int i = 0; i < 64; i++) begin
         if (m2_ff[i]) begin
            pos_in = 6'(i);
         end
      end
   end

   // floor shift down or plain shift up so the msb lands on NORM_MSB
   always_comb begin
      if (pos3_ff >= 6'(NORM_MSB)) begin
         xs_in = x3_ff >>> (pos3_ff - 6'(NORM_MSB));
         ys_in = y3_ff >>> (pos3_ff - 6'(NORM_MSB));
      end else begin
         xs_in = x3_ff <<< (6'(NORM_MSB) - pos3_ff);
         ys_in = y3_ff <<< (6'(NORM_MSB) - pos3_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff      <= vec_x;
         y1_ff      <= vec_y;
         mx1_ff     <= vec_x[63] ? -vec_x : vec_x;
         my1_ff     <= vec_y[63] ? -vec_y : vec_y;
         zero_ff[1] <= (vec_x == '0) && (vec_y == '0);
         x2_ff      <= x1_ff;
         y2_ff      <= y1_ff;
         m2_ff      <= (mx1_ff > my1_ff) ? mx1_ff : my1_ff;
         x3_ff      <= x2_ff;
         y3_ff      <= y2_ff;
         pos3_ff    <= pos_in;
         xn4_ff     <= VW'(xs_in);
         yn4_ff     <= VW'(ys_in);
         for (int k = 2; k < LAT; k++) begin
            zero_ff[k] <= zero_ff[k-1];
         end
         // quarter turn when x is negative
         if (xn4_ff < 0) begin
            if (yn4_ff >= 0) begin
               cx_ff[0] <= yn4_ff;
               cy_ff[0] <= -xn4_ff;
               cz_ff[0] <= scara_ik_pkg::HALF_PI_Q30;
            end else begin
               cx_ff[0] <= -yn4_ff;
               cy_ff[0] <= xn4_ff;
               cz_ff[0] <= -scara_ik_pkg::HALF_PI_Q30;
            end
         end else begin
            cx_ff[0] <= xn4_ff;
            cy_ff[0] <= yn4_ff;
            cz_ff[0] <= '0;
         end
         angle_ff <= zero_ff[LAT-1] ? '0 : 15'(zr >>> SH);
      end
   end

   for (genvar g = 0; g < CS; g++) begin : g_vec
      always_ff @(posedge clock) begin
         if (en) begin
            if (cy_ff[g] > 0) begin
               cx_ff[g+1] <= cx_ff[g] + (cy_ff[g] >>> g);
               cy_ff[g+1] <= cy_ff[g] - (cx_ff[g] >>> g);
               cz_ff[g+1] <= cz_ff[g] + ZW'(scara_ik_pkg::ATAN_TAB[g]);
            end else begin
               cx_ff[g+1] <= cx_ff[g] - (cy_ff[g] >>> g);
               cy_ff[g+1] <= cy_ff[g] + (cx_ff[g] >>> g);
               cz_ff[g+1] <= cz_ff[g] - ZW'(scara_ik_pkg::ATAN_TAB[g]);
            end
         end
      end
   end

   // round half up
   assign zr    = cz_ff[CS] + (ZW'(1) <<< (SH - 1));
   assign angle = angle_ff;

endmodule

FILE: rtl/scara_inverse_kinematics.sv
`timescale 1ns / 1ps
// scara inverse position kinematics, fully pipelined, one pose per cycle while the response is not stalled
//
//  port group   dir  beat contents (lowest bit first)
//  req_*        in   target_angle, target_x, target_y, target_z, elbow_negative
//  rsp_*        out  shoulder_angle, elbow_angle, lift_position, wrist_angle; tuser unreachable
//  csr_*        in   write of upper/lower link length, tool offset, vertical offset
//
//  one beat per cycle sustained while the response side is not stalled
//  the depth is set by the yaw rotation cordic, the 29 step square root and the atan2 units
//  reset clears the stage valid bits and loads the register defaults, no clearing pass
//  a stalled response beat freezes every stage at once, nothing is dropped or repeated
module scara_inverse_kinematics (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // target_angle, target_x, target_y, target_z, elbow_negative
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // shoulder_angle, elbow_angle, lift_position, wrist_angle
   output logic [0:0]  rsp_tuser,   // unreachable
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [13:0] csr_wdata
);

   localparam int CS     = scara_ik_pkg::CORDIC_STAGES;
   localparam int ZW     = scara_ik_pkg::ZW;
   localparam int RW     = 48;
   localparam int REM_W  = scara_ik_pkg::REM_W;
   localparam int STEPS  = scara_ik_pkg::SQRT_STEPS;

   localparam int ST_ROT  = 2;
   localparam int ST_OFS  = ST_ROT + CS + 1;
   localparam int ST_W    = ST_OFS + 1;
   localparam int ST_SQ   = ST_W + 1;
   localparam int ST_SUM  = ST_SQ + 1;
   localparam int ST_N    = ST_SUM + 1;
   localparam int ST_ABS  = ST_N + 1;
   localparam int ST_DD   = ST_ABS + 1;
   localparam int ST_REM  = ST_DD + 1;
   localparam int ST_ROOT = ST_REM + STEPS;
   localparam int ST_S    = ST_ROOT + 1;
   localparam int ST_MUL1 = ST_S + 1;
   localparam int ST_C    = ST_MUL1 + 1;
   localparam int ST_MUL2 = ST_C + 1;
   localparam int ST_VEC  = ST_MUL2 + 1;
   localparam int ST_ANG  = ST_VEC + scara_ik_pkg::ATAN_LAT;
   localparam int ST_OUT  = ST_ANG + 1;

   logic [13:0] upper_ff, lower_ff, tool_ff, vert_ff;

   logic                adv;
   logic [ST_OUT:1]     vld_ff;
   scara_ik_pkg::ctx_type ctx_ff [1:ST_ANG];
   scara_ik_pkg::ctx_type ctx_in [2:ST_ANG];
   scara_ik_pkg::ctx_type ctx1_in;

   logic signed [14:0] req_yaw, req_x, req_y, req_z;

   logic signed [ZW-1:0] yaw_q30, rz1_in, rz1_ff, fold_z;
   logic                 fold_flip;
   logic [43:0]          tprod;
   logic signed [RW-1:0] rx1_ff;
   logic signed [RW-1:0] rot_x_ff [0:CS];
   logic signed [RW-1:0] rot_y_ff [0:CS];
   logic signed [ZW-1:0] rot_z_ff [0:CS];
   logic signed [RW-1:0] ox_in, oy_in;
   logic signed [17:0]   ox_ff, oy_ff;

   logic [35:0] wx2_ff, wy2_ff, sw_ff, absn_ff;
   logic [27:0] l1s_ff, l2s_ff, lp_ff;
   logic [28:0] sl_ff;
   logic [REM_W-1:0] dd_ff, nn_ff;
   logic [REM_W-1:0] sq_v_ff [0:STEPS];
   logic [REM_W-1:0] sq_r_ff [0:STEPS];

   logic signed [14:0] l2_sgn;
   logic signed [44:0] a_ff, c1_ff, a2_ff;
   logic [42:0]        c2_ff;
   logic signed [45:0] c_ff;
   logic signed [63:0] cwy_ff, awx_ff, cwx_ff, awy_ff, vy_ff, vx_ff;
   logic signed [29:0] vec_n;
   logic signed [14:0] q1, q2;

   logic signed [14:0] sh_ff, el_ff;
   logic signed [15:0] lift_ff;
   logic signed [16:0] wr_ff;
   logic               unr_ff;

   assign req_yaw = signed'(req_tdata[14:0]);
   assign req_x   = signed'(req_tdata[29:15]);
   assign req_y   = signed'(req_tdata[44:30]);
   assign req_z   = signed'(req_tdata[59:45]);

   // the output register is the last stage, everything moves together
   assign adv        = ~vld_ff[ST_OUT] | rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff <= 14'd4960;
         lower_ff <= 14'd4160;
         tool_ff  <= 14'd1440;
         vert_ff  <= 14'd3599;
      end else if (csr_we) begin
         case (csr_index)
            scara_ik_pkg::CSR_UPPER_LINK:  upper_ff <= csr_wdata;
            scara_ik_pkg::CSR_LOWER_LINK:  lower_ff <= csr_wdata;
            scara_ik_pkg::CSR_TOOL_OFFSET: tool_ff  <= csr_wdata;
            scara_ik_pkg::CSR_VERT_OFFSET: vert_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[ST_OUT-1:1], req_tvalid};
      end
   end

   // yaw into (-pi, pi], then folded into [-pi/2, pi/2]
   always_comb begin
      yaw_q30 = ZW'(req_yaw) <<< scara_ik_pkg::ANG_SHIFT;
      if (yaw_q30 > scara_ik_pkg::PI_Q30) begin
         rz1_in = yaw_q30 - scara_ik_pkg::TWO_PI_Q30;
      end else if (yaw_q30 <= -scara_ik_pkg::PI_Q30) begin
         rz1_in = yaw_q30 + scara_ik_pkg::TWO_PI_Q30;
      end else begin
         rz1_in = yaw_q30;
      end
      if (rz1_ff > scara_ik_pkg::HALF_PI_Q30) begin
         fold_z    = rz1_ff - scara_ik_pkg::PI_Q30;
         fold_flip = 1'b1;
      end else if (rz1_ff < -scara_ik_pkg::HALF_PI_Q30) begin
         fold_z    = rz1_ff + scara_ik_pkg::PI_Q30;
         fold_flip = 1'b1;
      end else begin
         fold_z    = rz1_ff;
         fold_flip = 1'b0;
      end
   end

   assign tprod = 44'(tool_ff) * 44'(scara_ik_pkg::GAIN_Q30);

   always_comb begin
      ctx1_in      = '0;
      ctx1_in.yaw  = req_yaw;
      ctx1_in.px   = req_x;
      ctx1_in.py   = req_y;
      ctx1_in.neg  = req_tdata[60];
      ctx1_in.lift = 16'(req_z) - 16'(vert_ff);
   end

   // negate on flip folded into the rounding add as ~x + 1
   assign ox_in = (ctx_ff[ST_OFS-1].flip ? ~rot_x_ff[CS] : rot_x_ff[CS])
                  + (RW'(1) <<< 29) + RW'(ctx_ff[ST_OFS-1].flip);
   assign oy_in = (ctx_ff[ST_OFS-1].flip ? ~rot_y_ff[CS] : rot_y_ff[CS])
                  + (RW'(1) <<< 29) + RW'(ctx_ff[ST_OFS-1].flip);

   always_comb begin
      for (int k = 2; k <= ST_ANG; k++) begin
         ctx_in[k] = ctx_ff[k-1];
      end
      ctx_in[ST_ROT].flip = fold_flip;
      ctx_in[ST_W].wx     = 18'(ctx_ff[ST_OFS].px) - ox_ff;
      ctx_in[ST_W].wy     = 18'(ctx_ff[ST_OFS].py) - oy_ff;
      ctx_in[ST_SUM].d    = {lp_ff, 1'b0};
      ctx_in[ST_N].n      = 37'(sw_ff) - 37'(sl_ff);
      ctx_in[ST_DD].unr   = (ctx_ff[ST_ABS].d == '0) || (absn_ff > 36'(ctx_ff[ST_ABS].d));
      ctx_in[ST_S].s      = ctx_ff[ST_ROOT].neg ? -(30'(sq_r_ff[STEPS]))
                                                :   30'(sq_r_ff[STEPS]);
   end

   assign l2_sgn = signed'({1'b0, lower_ff});
   assign vec_n  = signed'(ctx_ff[ST_VEC].n[29:0]);

   always_ff @(posedge clock) begin
      if (adv) begin
         ctx_ff[1] <= ctx1_in;
         for (int k = 2; k <= ST_ANG; k++) begin
            ctx_ff[k] <= ctx_in[k];
         end
         rz1_ff      <= rz1_in;
         rx1_ff      <= RW'(tprod);
         rot_x_ff[0] <= rx1_ff;
         rot_y_ff[0] <= '0;
         rot_z_ff[0] <= fold_z;
         ox_ff       <= ox_in[RW-1:30];
         oy_ff       <= oy_in[RW-1:30];
         // squares of the wrist point and link lengths, and the link length product
         wx2_ff      <= 36'(ctx_ff[ST_W].wx) * 36'(ctx_ff[ST_W].wx);
         wy2_ff      <= 36'(ctx_ff[ST_W].wy) * 36'(ctx_ff[ST_W].wy);
         l1s_ff      <= 28'(upper_ff) * 28'(upper_ff);
         l2s_ff      <= 28'(lower_ff) * 28'(lower_ff);
         lp_ff       <= 28'(upper_ff) * 28'(lower_ff);
         sw_ff       <= wx2_ff + wy2_ff;
         sl_ff       <= 29'(l1s_ff) + 29'(l2s_ff);
         absn_ff     <= 36'(ctx_ff[ST_N].n[36] ? -ctx_ff[ST_N].n : ctx_ff[ST_N].n);
         dd_ff       <= REM_W'(ctx_ff[ST_ABS].d) * REM_W'(ctx_ff[ST_ABS].d);
         nn_ff       <= REM_W'(absn_ff[28:0]) * REM_W'(absn_ff[28:0]);
         sq_v_ff[0]  <= dd_ff - nn_ff;
         sq_r_ff[0]  <= '0;
         // elbow terms scaled by 2 l1 l2
         a_ff        <= 45'(l2_sgn) * 45'(ctx_ff[ST_S].s);
         c1_ff       <= 45'(l2_sgn) * 45'(signed'(ctx_ff[ST_S].n[29:0]));
         c2_ff       <= 43'(upper_ff) * 43'(ctx_ff[ST_S].d);
         c_ff        <= 46'(c1_ff) + 46'(c2_ff);
         a2_ff       <= a_ff;
         cwy_ff      <= 64'(c_ff) * 64'(ctx_ff[ST_C].wy);
         awx_ff      <= 64'(a2_ff) * 64'(ctx_ff[ST_C].wx);
         cwx_ff      <= 64'(c_ff) * 64'(ctx_ff[ST_C].wx);
         awy_ff      <= 64'(a2_ff) * 64'(ctx_ff[ST_C].wy);
         vy_ff       <= cwy_ff - awx_ff;
         vx_ff       <= cwx_ff + awy_ff;
         // response register
         unr_ff      <= ctx_ff[ST_ANG].unr;
         lift_ff     <= ctx_ff[ST_ANG].lift;
         sh_ff       <= ctx_ff[ST_ANG].unr ? '0 : q1;
         el_ff       <= ctx_ff[ST_ANG].unr ? '0 : q2;
         wr_ff       <= ctx_ff[ST_ANG].unr ? '0
                        : 17'(ctx_ff[ST_ANG].yaw) - 17'(q1) - 17'(q2);
      end
   end

   // rotation cordic for the tool offset vector
   for (genvar g = 0; g < CS; g++) begin : g_rot
      always_ff @(posedge clock) begin
         if (adv) begin
            if (rot_z_ff[g] >= 0) begin
               rot_x_ff[g+1] <= rot_x_ff[g] - (rot_y_ff[g] >>> g);
               rot_y_ff[g+1] <= rot_y_ff[g] + (rot_x_ff[g] >>> g);
               rot_z_ff[g+1] <= rot_z_ff[g] - ZW'(scara_ik_pkg::ATAN_TAB[g]);
            end else begin
               rot_x_ff[g+1] <= rot_x_ff[g] + (rot_y_ff[g] >>> g);
               rot_y_ff[g+1] <= rot_y_ff[g] - (rot_x_ff[g] >>> g);
               rot_z_ff[g+1] <= rot_z_ff[g] + ZW'(scara_ik_pkg::ATAN_TAB[g]);
            end
         end
      end
   end

   // restoring square root, one result bit per stage
   for (genvar j = 0; j < STEPS; j++) begin : g_sqrt
      localparam logic [REM_W-1:0] BIT = REM_W'(1) << (REM_W - 2 - 2 * j);
      logic [REM_W-1:0] trial;
      assign trial = sq_r_ff[j] + BIT;
      always_ff @(posedge clock) begin
         if (adv) begin
            if (sq_v_ff[j] >= trial) begin
               sq_v_ff[j+1] <= sq_v_ff[j] - trial;
               sq_r_ff[j+1] <= (sq_r_ff[j] >> 1) + BIT;
            end else begin
               sq_v_ff[j+1] <= sq_v_ff[j];
               sq_r_ff[j+1] <= sq_r_ff[j] >> 1;
            end
         end
      end
   end

   scara_ik_atan2 u_shoulder (
      .clock (clock),
      .en    (adv),
      .vec_y (vy_ff),
      .vec_x (vx_ff),
      .angle (q1)
   );

   scara_ik_atan2 u_elbow (
      .clock (clock),
      .en    (adv),
      .vec_y (64'(ctx_ff[ST_VEC].s)),
      .vec_x (64'(vec_n)),
      .angle (q2)
   );

   assign rsp_tvalid = vld_ff[ST_OUT];
   assign rsp_tdata  = {1'b0, wr_ff, lift_ff, el_ff, sh_ff};
   assign rsp_tuser  = unr_ff;

   a_unreach_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[29:0] == '0 && rsp_tdata[62:46] == '0)
      else $error("unreachable beat with nonzero angles");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[1])
      else $error("accepted beat did not enter the pipeline");

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved during a stall");

   a_zero_link: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_DD] && ctx_ff[ST_DD].d == '0 |-> ctx_ff[ST_DD].unr)
      else $error("zero link product not flagged unreachable");

endmodule
